// ===== hw/rtl/ncs_pkg.sv =====
// ----------------------------------------------------------------------------
// ncs_pkg
// Shared types and constants of the nearest palette colour search block.
// ----------------------------------------------------------------------------
package ncs_pkg;

    localparam int DEFAULT_PALETTE_ENTRIES = 256;

    localparam int CHANNEL_W = 8;
    localparam int COLOUR_W  = 3 * CHANNEL_W;
    localparam int INDEX_W   = 8;
    localparam int SQUARE_W  = 2 * CHANNEL_W;
    localparam int DIST_W    = 18;

    // 256*256*3, above any possible distance
    localparam logic [DIST_W-1:0] SEARCH_BOUND = DIST_W'(256 * 256 * 3);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef struct packed {
        logic [CHANNEL_W-1:0] red;
        logic [CHANNEL_W-1:0] green;
        logic [CHANNEL_W-1:0] blue;
    } colour_t;

    // travels alongside each palette read through the distance pipe
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } tag_t;

endpackage

// ===== hw/rtl/ncs_ram.sv =====
// ----------------------------------------------------------------------------
// ncs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ncs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ncs_dist.sv =====
// ----------------------------------------------------------------------------
// ncs_dist
// Two-stage distance pipe: squared channel differences, then sum and
// running minimum. Lowest index wins on a tie.
// ----------------------------------------------------------------------------
module ncs_dist #(
    parameter int IDX_W = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ncs_pkg::tag_t         tag_in,
    input  logic [IDX_W-1:0]      idx_in,
    input  ncs_pkg::colour_t      entry,
    input  ncs_pkg::colour_t      query,
    output logic                  done,
    output logic [IDX_W-1:0]      best_idx
);

    import ncs_pkg::*;

    function automatic logic [SQUARE_W-1:0] sq_diff(
        input logic [CHANNEL_W-1:0] a,
        input logic [CHANNEL_W-1:0] b
    );
        logic [CHANNEL_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQUARE_W'(d) * SQUARE_W'(d);
    endfunction

    tag_t                tag1_reg;
    logic [IDX_W-1:0]    idx1_reg;
    logic [SQUARE_W-1:0] sq_red_reg, sq_green_reg, sq_blue_reg;

    logic [DIST_W-1:0]   entry_dist;
    logic [DIST_W-1:0]   ref_dist;
    logic [IDX_W-1:0]    ref_idx;
    logic [DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic                done_reg;

    // stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
        end else begin
            tag1_reg <= tag_in;
        end
        idx1_reg     <= idx_in;
        sq_red_reg   <= sq_diff(entry.red, query.red);
        sq_green_reg <= sq_diff(entry.green, query.green);
        sq_blue_reg  <= sq_diff(entry.blue, query.blue);
    end

    // stage 2
    always_comb begin
        entry_dist = DIST_W'(sq_red_reg) + DIST_W'(sq_green_reg) + DIST_W'(sq_blue_reg);
        ref_dist   = tag1_reg.first ? SEARCH_BOUND : best_dist_reg;
        ref_idx    = tag1_reg.first ? '0 : best_idx_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        if (tag1_reg.valid) begin
            if (entry_dist < ref_dist) begin
                best_dist_next = entry_dist;
                best_idx_next  = idx1_reg;
            end else begin
                best_dist_next = ref_dist;
                best_idx_next  = ref_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= tag1_reg.valid && tag1_reg.last;
        end
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
    end

    assign done     = done_reg;
    assign best_idx = best_idx_reg;

endmodule

// ===== hw/rtl/nearest_palette_color_search.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette store with nearest-colour lookup by squared RGB distance.
// ----------------------------------------------------------------------------
// A write item (tuser = 0) stores one colour in the palette when it is
// accepted; an index at or above PALETTE_ENTRIES stores nothing. Every write
// drops the one-entry answer cache. A query item (tuser = 1) whose colour
// repeats the previous query is answered from the cache, passing through
// the done state to the output register; any other query reads the palette
// RAM one entry per cycle through its single read port, then drains the
// distance pipe before the result item is offered. The block takes one item
// at a time; a finished result waits in the output register while the next
// item is accepted. Palette entries must be written before the first query.
// ----------------------------------------------------------------------------
module nearest_palette_color_search #(
    parameter int PALETTE_ENTRIES = ncs_pkg::DEFAULT_PALETTE_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_index, red, green, blue
    input  logic [0:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // best_index
);

    import ncs_pkg::*;

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(PALETTE_ENTRIES - 1);
    localparam logic [INDEX_W:0] ENTRY_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    colour_t             query_reg, query_next;
    logic [INDEX_W-1:0]  result_reg, result_next;
    logic                cache_valid_reg, cache_valid_next;
    colour_t             cached_colour_reg, cached_colour_next;
    logic [INDEX_W-1:0]  cached_index_reg, cached_index_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;
    tag_t                tag_rd_reg;
    tag_t                tag_issue;
    logic [AW-1:0]       idx_rd_reg;

    logic                accept;
    cmd_t                cmd;
    logic [INDEX_W-1:0]  in_index;
    colour_t             in_colour;
    logic                ram_we;
    colour_t             ram_rdata;
    logic                ram_re;
    logic                dist_done;
    logic [AW-1:0]       dist_best;

    assign cmd       = cmd_t'(s_tuser[0]);
    assign in_index  = s_tdata[7:0];
    assign in_colour = '{red: s_tdata[15:8], green: s_tdata[23:16], blue: s_tdata[31:24]};
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign ram_we    = accept && (cmd == CMD_WRITE) && ({1'b0, in_index} < ENTRY_LIMIT);
    assign ram_re    = (state_reg == ST_SCAN);

    assign tag_issue.valid = ram_re;
    assign tag_issue.first = (cnt_reg == '0);
    assign tag_issue.last  = (cnt_reg == LAST_ADDR);

    ncs_ram #(
        .WIDTH (COLOUR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_index[AW-1:0]),
        .wdata (in_colour),
        .re    (ram_re),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    ncs_dist #(
        .IDX_W (AW)
    ) u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .tag_in   (tag_rd_reg),
        .idx_in   (idx_rd_reg),
        .entry    (ram_rdata),
        .query    (query_reg),
        .done     (dist_done),
        .best_idx (dist_best)
    );

    always_comb begin
        state_next         = state_reg;
        cnt_next           = cnt_reg;
        query_next         = query_reg;
        result_next        = result_reg;
        cache_valid_next   = cache_valid_reg;
        cached_colour_next = cached_colour_reg;
        cached_index_next  = cached_index_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        out_index_next     = out_index_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (cmd == CMD_WRITE) begin
                        cache_valid_next = 1'b0;
                    end else if (cache_valid_reg && (cached_colour_reg == in_colour)) begin
                        query_next  = in_colour;
                        result_next = cached_index_reg;
                        state_next  = ST_DONE;
                    end else begin
                        query_next = in_colour;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (dist_done) begin
                    result_next = INDEX_W'(dist_best);
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next     = 1'b1;
                    out_index_next     = result_reg;
                    cache_valid_next   = 1'b1;
                    cached_colour_next = query_reg;
                    cached_index_next  = result_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            cache_valid_reg   <= 1'b0;
            cached_colour_reg <= '0;
            cached_index_reg  <= '0;
            out_valid_reg     <= 1'b0;
            tag_rd_reg        <= '0;
        end else begin
            state_reg         <= state_next;
            cnt_reg           <= cnt_next;
            cache_valid_reg   <= cache_valid_next;
            cached_colour_reg <= cached_colour_next;
            cached_index_reg  <= cached_index_next;
            out_valid_reg     <= out_valid_next;
            tag_rd_reg        <= tag_issue;
        end
        idx_rd_reg    <= cnt_reg;
        query_reg     <= query_next;
        result_reg    <= result_next;
        out_index_reg <= out_index_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_index_reg;

endmodule
